// File: src/kalman_filter_predict_update_assert.svh
// ----------------------------------------------------------------------------
// Kalman filter assertion macros
// Shorthand for the clocked, reset-qualified properties of the checker.
// ----------------------------------------------------------------------------
`ifndef KALMAN_FILTER_PREDICT_UPDATE_ASSERT_SVH
`define KALMAN_FILTER_PREDICT_UPDATE_ASSERT_SVH

// Same-cycle implication.
`define KFPU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KFPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/kfpu_pkg.sv
// ----------------------------------------------------------------------------
// Kalman filter package
// Default dimensions, item kinds, load targets and status codes.
// ----------------------------------------------------------------------------
package kfpu_pkg;

  localparam int DEF_STATE_DIM = 4;
  localparam int DEF_MEAS_DIM  = 2;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_PREDICT = 2'd1;
  localparam logic [1:0] KIND_UPDATE  = 2'd2;

  localparam logic [2:0] TGT_X = 3'd0;
  localparam logic [2:0] TGT_P = 3'd1;
  localparam logic [2:0] TGT_F = 3'd2;
  localparam logic [2:0] TGT_Q = 3'd3;
  localparam logic [2:0] TGT_H = 3'd4;
  localparam logic [2:0] TGT_R = 3'd5;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_SINGULAR = 2'd1;
  localparam logic [1:0] STS_BAD_LOAD = 2'd2;

endpackage

// File: src/kalman_filter_predict_update.sv
// ----------------------------------------------------------------------------
// Four-state linear Kalman filter
// Fixed-point predict and measurement update on one shared multiply unit.
// ----------------------------------------------------------------------------
// A user raises start with an item while busy is low; the item transfers at
// that edge. A load writes one element of x, P, F, Q, H or R, and a no-op
// kind does nothing; both return their result in the cycle after the transfer.
// A predict computes x = F x and P = F P F' + Q. An update computes
// S = H P H' + R, K = P H' S^-1, x += K (z - H x) and P = P - K H P; a zero
// determinant of S leaves x and P alone and reports a singular status.
// Every item returns exactly one result: out_valid is high for one cycle
// with the estimate and the status, and the receiver cannot stall, so the
// result must be captured in that cycle. All arithmetic runs through one
// 32x32 multiplier followed by a rounding accumulator, with a multiply
// state and an accumulate state per product, and one restoring divider
// that retires one quotient bit a cycle. With N = STATE_DIM and
// M = MEAS_DIM, an update performs one division for each of the M N
// gain elements. busy stays high for the whole computation. Stores are
// not cleared by reset; a read of an element that was never loaded gives
// an unknown value.
// ----------------------------------------------------------------------------
module kalman_filter_predict_update #(
  parameter int STATE_DIM = kfpu_pkg::DEF_STATE_DIM,
  parameter int MEAS_DIM  = kfpu_pkg::DEF_MEAS_DIM,
  parameter int FRAC_BITS = kfpu_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [2:0]         in_target,
  input  logic [1:0]         in_row,
  input  logic [1:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_z_first,
  input  logic signed [31:0] in_z_second,
  output logic               out_valid,
  output logic signed [31:0] out_est_0,
  output logic signed [31:0] out_est_1,
  output logic signed [31:0] out_est_2,
  output logic signed [31:0] out_est_3,
  output logic [1:0]         out_status
);

  // Accumulator holds up to four rounded products plus one 32-bit term.
  localparam int ACC_W = 68 - FRAC_BITS;
  localparam int DW    = ACC_W + FRAC_BITS;
  localparam int RW    = ACC_W + 1;

  localparam logic [1:0] N_LAST = 2'(STATE_DIM - 1);
  localparam logic [1:0] M_LAST = 2'(MEAS_DIM - 1);

  localparam logic signed [63:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE_Q  = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(64'shFFFF_FFFF_8000_0000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_DIVI, ST_DIVS, ST_DIVF
  } state_t;

  // Each phase is one matrix product: rows i, columns j, inner index k.
  typedef enum logic [3:0] {
    PH_FX, PH_FP, PH_FPF, PH_HX, PH_PHT, PH_S, PH_DET, PH_NUM, PH_KH, PH_NP, PH_XK
  } phase_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) r = 32'sh7FFF_FFFF;
    else if (v < SAT_LO) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  state_t state_r;
  phase_t phase_r;
  logic [1:0] i_r, j_r, k_r;
  logic       out_valid_r;
  logic [1:0] status_r;

  // Filter stores.
  logic signed [31:0] x_r [4];
  logic signed [31:0] p_r [4][4];
  logic signed [31:0] f_r [4][4];
  logic signed [31:0] q_r [4][4];
  logic signed [31:0] h_r [2][4];
  logic signed [31:0] r_r [2][2];

  // Intermediate results.
  logic signed [31:0] nx_r [4];
  logic signed [31:0] t1_r [4][4];  // F P, later K H
  logic signed [31:0] t2_r [4][4];  // P H', later the new P
  logic signed [31:0] s_r  [2][2];
  logic signed [31:0] kg_r [4][2];
  logic signed [31:0] y_r  [2];
  logic signed [31:0] z_r  [2];
  logic signed [ACC_W-1:0] det_r;

  // Multiply-accumulate datapath.
  logic signed [63:0]      prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;

  // Divider.
  logic [RW-1:0]    rem_r;
  logic [31:0]      dvl_r;
  logic [ACC_W-1:0] ud_r;
  logic [31:0]      quo_r;
  logic             neg_r;
  logic             ovf_r;
  logic [5:0]       cnt_r;

  // Operand selection.
  logic [1:0] f_row, p_row, p_col, h_col, x_idx, t2_row, t2_col;
  logic       h_row;
  logic signed [31:0] f_rd, p_rd, h_rd, x_rd, t1_rd, t2_rd, kg_rd, s_opa, s_opb;
  logic signed [31:0] opa, opb, init32;
  logic               sub;
  logic signed [63:0] rsum;
  logic signed [ACC_W-1:0] rnd, base, y_diff;
  logic [1:0] ni_last, nj_last, nk_last, nxt_i, nxt_j;
  logic       k_last, phase_end, advance, load_ok;
  phase_t     phase_after;
  logic [ACC_W-1:0] ua, ud;
  logic [DW-1:0]    dvd;
  logic [RW-1:0]    trial;
  logic signed [31:0] div_res;

  always_comb begin
    f_row = (phase_r == PH_FPF) ? j_r : i_r;
    f_rd  = f_r[f_row][k_r];

    case (phase_r)
      PH_FP:   begin p_row = k_r; p_col = j_r; end
      PH_PHT:  begin p_row = i_r; p_col = k_r; end
      default: begin p_row = (state_r == ST_ACC) ? i_r : k_r; p_col = j_r; end
    endcase
    p_rd = p_r[p_row][p_col];

    case (phase_r)
      PH_PHT:  begin h_row = j_r[0]; h_col = k_r; end
      PH_KH:   begin h_row = k_r[0]; h_col = j_r; end
      default: begin h_row = i_r[0]; h_col = k_r; end
    endcase
    h_rd = h_r[h_row][h_col];

    x_idx = (phase_r == PH_XK) ? i_r : k_r;
    x_rd  = x_r[x_idx];
    t1_rd = t1_r[i_r][k_r];

    // During the numerators, column j^k picks P H' element a or b.
    if (phase_r == PH_S) begin
      t2_row = k_r;
      t2_col = j_r;
    end else begin
      t2_row = i_r;
      t2_col = {1'b0, j_r[0] ^ k_r[0]};
    end
    t2_rd = t2_r[t2_row][t2_col];
    kg_rd = kg_r[i_r][k_r[0]];

    // det = S00 S11 - S01 S10; adjugate numerators pair with S the same way.
    if (phase_r == PH_DET) begin
      s_opa = (k_r == 2'd0) ? s_r[0][0] : s_r[0][1];
      s_opb = (k_r == 2'd0) ? ((MEAS_DIM == 2) ? s_r[1][1] : ONE_Q) : s_r[1][0];
    end else begin
      s_opa = t2_rd;
      if (MEAS_DIM == 1) s_opb = ONE_Q;
      else if (j_r[0] == 1'b0) s_opb = (k_r == 2'd0) ? s_r[1][1] : s_r[1][0];
      else s_opb = (k_r == 2'd0) ? s_r[0][0] : s_r[0][1];
    end

    case (phase_r)
      PH_FX:   begin opa = f_rd;  opb = x_rd;  end
      PH_FP:   begin opa = f_rd;  opb = p_rd;  end
      PH_FPF:  begin opa = t1_rd; opb = f_rd;  end
      PH_HX:   begin opa = h_rd;  opb = x_rd;  end
      PH_PHT:  begin opa = p_rd;  opb = h_rd;  end
      PH_S:    begin opa = h_rd;  opb = t2_rd; end
      PH_DET:  begin opa = s_opa; opb = s_opb; end
      PH_NUM:  begin opa = s_opa; opb = s_opb; end
      PH_KH:   begin opa = kg_rd; opb = h_rd;  end
      PH_NP:   begin opa = t1_rd; opb = p_rd;  end
      PH_XK:   begin opa = kg_rd; opb = y_r[k_r[0]]; end
      default: begin opa = f_rd;  opb = x_rd;  end
    endcase

    case (phase_r)
      PH_FPF:  init32 = q_r[i_r][j_r];
      PH_S:    init32 = r_r[i_r[0]][j_r[0]];
      PH_NP:   init32 = p_rd;
      PH_XK:   init32 = x_rd;
      default: init32 = '0;
    endcase
    sub = (phase_r == PH_NP) ||
          (((phase_r == PH_DET) || (phase_r == PH_NUM)) && (k_r == 2'd1));

    // Round to nearest, ties up, then accumulate.
    rsum    = prod_r + HALF_Q;
    rnd     = ACC_W'(rsum >>> FRAC_BITS);
    base    = (k_r == 2'd0) ? ACC_W'(init32) : acc_r;
    acc_nxt = sub ? (base - rnd) : (base + rnd);
    y_diff  = ACC_W'(z_r[i_r[0]]) - ACC_W'(sat32(acc_nxt));

    case (phase_r)
      PH_FX:   begin ni_last = N_LAST; nj_last = 2'd0;   nk_last = N_LAST; end
      PH_HX:   begin ni_last = M_LAST; nj_last = 2'd0;   nk_last = N_LAST; end
      PH_PHT:  begin ni_last = N_LAST; nj_last = M_LAST; nk_last = N_LAST; end
      PH_S:    begin ni_last = M_LAST; nj_last = M_LAST; nk_last = N_LAST; end
      PH_DET:  begin ni_last = 2'd0;   nj_last = 2'd0;   nk_last = M_LAST; end
      PH_NUM:  begin ni_last = N_LAST; nj_last = M_LAST; nk_last = M_LAST; end
      PH_KH:   begin ni_last = N_LAST; nj_last = N_LAST; nk_last = M_LAST; end
      PH_XK:   begin ni_last = N_LAST; nj_last = 2'd0;   nk_last = M_LAST; end
      default: begin ni_last = N_LAST; nj_last = N_LAST; nk_last = N_LAST; end
    endcase
    k_last = (k_r == nk_last);

    if (j_r != nj_last) begin
      nxt_j = j_r + 2'd1;
      nxt_i = i_r;
    end else begin
      nxt_j = 2'd0;
      nxt_i = i_r + 2'd1;
    end
    phase_end = (j_r == nj_last) && (i_r == ni_last);
    advance   = ((state_r == ST_ACC) && k_last && (phase_r != PH_NUM)) ||
                (state_r == ST_DIVF);

    case (phase_r)
      PH_FX:   phase_after = PH_FP;
      PH_FP:   phase_after = PH_FPF;
      PH_HX:   phase_after = PH_PHT;
      PH_PHT:  phase_after = PH_S;
      PH_S:    phase_after = PH_DET;
      PH_DET:  phase_after = PH_NUM;
      PH_NUM:  phase_after = PH_KH;
      PH_KH:   phase_after = PH_NP;
      PH_NP:   phase_after = PH_XK;
      default: phase_after = PH_FX;
    endcase

    case (in_target)
      kfpu_pkg::TGT_X: load_ok = 32'(in_row) < STATE_DIM;
      kfpu_pkg::TGT_P, kfpu_pkg::TGT_F, kfpu_pkg::TGT_Q:
        load_ok = (32'(in_row) < STATE_DIM) && (32'(in_col) < STATE_DIM);
      kfpu_pkg::TGT_H:
        load_ok = (32'(in_row) < MEAS_DIM) && (32'(in_col) < STATE_DIM);
      kfpu_pkg::TGT_R:
        load_ok = (32'(in_row) < MEAS_DIM) && (32'(in_col) < MEAS_DIM);
      default: load_ok = 1'b0;
    endcase

    ua    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    ud    = det_r[ACC_W-1] ? ACC_W'(-det_r) : ACC_W'(det_r);
    dvd   = {ua, {FRAC_BITS{1'b0}}};
    trial = {rem_r[RW-2:0], dvl_r[31]};

    if (neg_r) div_res = (ovf_r || quo_r[31]) ? 32'sh8000_0000 : -$signed(quo_r);
    else       div_res = (ovf_r || quo_r[31]) ? 32'sh7FFF_FFFF : $signed(quo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FX;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      status_r    <= kfpu_pkg::STS_OK;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            i_r <= '0;
            j_r <= '0;
            k_r <= '0;
            case (in_kind)
              kfpu_pkg::KIND_LOAD: begin
                out_valid_r <= 1'b1;
                status_r    <= load_ok ? kfpu_pkg::STS_OK : kfpu_pkg::STS_BAD_LOAD;
                if (load_ok) begin
                  case (in_target)
                    kfpu_pkg::TGT_X: x_r[in_row] <= in_value;
                    kfpu_pkg::TGT_P: p_r[in_row][in_col] <= in_value;
                    kfpu_pkg::TGT_F: f_r[in_row][in_col] <= in_value;
                    kfpu_pkg::TGT_Q: q_r[in_row][in_col] <= in_value;
                    kfpu_pkg::TGT_H: h_r[in_row[0]][in_col] <= in_value;
                    default:         r_r[in_row[0]][in_col[0]] <= in_value;
                  endcase
                end
              end
              kfpu_pkg::KIND_PREDICT: begin
                phase_r <= PH_FX;
                state_r <= ST_MUL;
              end
              kfpu_pkg::KIND_UPDATE: begin
                z_r[0]  <= in_z_first;
                z_r[1]  <= in_z_second;
                phase_r <= PH_HX;
                state_r <= ST_MUL;
              end
              default: begin
                out_valid_r <= 1'b1;
                status_r    <= kfpu_pkg::STS_OK;
              end
            endcase
          end
        end
        ST_MUL: begin
          prod_r  <= 64'(opa) * 64'(opb);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!k_last) begin
            acc_r   <= acc_nxt;
            k_r     <= k_r + 2'd1;
            state_r <= ST_MUL;
          end else begin
            k_r <= '0;
            case (phase_r)
              PH_FX:   nx_r[i_r] <= sat32(acc_nxt);
              PH_FP:   t1_r[i_r][j_r] <= sat32(acc_nxt);
              PH_FPF:  p_r[i_r][j_r] <= sat32(acc_nxt);
              PH_HX:   y_r[i_r[0]] <= sat32(y_diff);
              PH_PHT:  t2_r[i_r][j_r] <= sat32(acc_nxt);
              PH_S:    s_r[i_r[0]][j_r[0]] <= sat32(acc_nxt);
              PH_DET:  det_r <= acc_nxt;
              PH_NUM: begin
                acc_r   <= acc_nxt;
                state_r <= ST_DIVI;
              end
              PH_KH:   t1_r[i_r][j_r] <= sat32(acc_nxt);
              PH_NP:   t2_r[i_r][j_r] <= sat32(acc_nxt);
              default: x_r[i_r] <= sat32(acc_nxt);
            endcase
          end
        end
        ST_DIVI: begin
          rem_r   <= RW'(dvd[DW-1:32]);
          dvl_r   <= dvd[31:0];
          ud_r    <= ud;
          neg_r   <= acc_r[ACC_W-1] ^ det_r[ACC_W-1];
          cnt_r   <= '0;
          state_r <= ST_DIVS;
        end
        ST_DIVS: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd0) begin
            // Integer part of 2^32 or more saturates regardless of the rest.
            ovf_r <= rem_r >= RW'(ud_r);
          end else begin
            if (trial >= RW'(ud_r)) begin
              rem_r <= trial - RW'(ud_r);
              quo_r <= {quo_r[30:0], 1'b1};
            end else begin
              rem_r <= trial;
              quo_r <= {quo_r[30:0], 1'b0};
            end
            dvl_r <= {dvl_r[30:0], 1'b0};
            if (cnt_r == 6'd32) state_r <= ST_DIVF;
          end
        end
        ST_DIVF: begin
          kg_r[i_r][j_r[0]] <= div_res;
        end
        default: state_r <= ST_IDLE;
      endcase

      if (advance) begin
        if (!phase_end) begin
          i_r     <= nxt_i;
          j_r     <= nxt_j;
          state_r <= ST_MUL;
        end else begin
          i_r <= '0;
          j_r <= '0;
          if (phase_r == PH_FPF) begin
            x_r         <= nx_r;
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            status_r    <= kfpu_pkg::STS_OK;
          end else if (phase_r == PH_XK) begin
            p_r         <= t2_r;
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            status_r    <= kfpu_pkg::STS_OK;
          end else if ((phase_r == PH_DET) && (acc_nxt == '0)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
            status_r    <= kfpu_pkg::STS_SINGULAR;
          end else begin
            phase_r <= phase_after;
            state_r <= ST_MUL;
          end
        end
      end
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = status_r;
  assign out_est_0  = x_r[0];
  assign out_est_1  = x_r[1];
  assign out_est_2  = (STATE_DIM > 2) ? x_r[2] : 32'sd0;
  assign out_est_3  = (STATE_DIM > 3) ? x_r[3] : 32'sd0;

endmodule

// File: src/kfpu_checker.sv
// ----------------------------------------------------------------------------
// Kalman filter port checker
// Watches the command and result ports of the filter over time.
// ----------------------------------------------------------------------------
`include "kalman_filter_predict_update_assert.svh"

module kfpu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_kind,
  input logic       out_valid,
  input logic [1:0] out_status
);

  logic [1:0] kind_r;
  logic       xfer;

  assign xfer = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= kfpu_pkg::KIND_LOAD;
    end else if (xfer) begin
      kind_r <= in_kind;
    end
  end

  `KFPU_ASSERT_NEXT(a_load_answers, xfer && (in_kind == kfpu_pkg::KIND_LOAD), out_valid, "load result missing")
  `KFPU_ASSERT_NEXT(a_predict_busy, xfer && (in_kind == kfpu_pkg::KIND_PREDICT), busy && !out_valid, "predict did not start")
  `KFPU_ASSERT_NOW(a_result_idle, out_valid, !busy, "result while still busy")
  `KFPU_ASSERT_NOW(a_singular_src, out_valid && (out_status == kfpu_pkg::STS_SINGULAR), kind_r == kfpu_pkg::KIND_UPDATE, "singular status outside an update")
  `KFPU_ASSERT_NOW(a_badload_src, out_valid && (out_status == kfpu_pkg::STS_BAD_LOAD), kind_r == kfpu_pkg::KIND_LOAD, "bad-load status outside a load")

endmodule

bind kalman_filter_predict_update kfpu_checker u_kfpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_kind    (in_kind),
  .out_valid  (out_valid),
  .out_status (out_status)
);
